// ===== rtl/e2q_pkg.sv =====
// shared constants, payload types and arctangent table for the euler to quaternion block
`timescale 1ns / 1ps
`default_nettype none
package e2q_pkg;

    // angle and result formats
    localparam int ANGLE_BITS    = 16;
    localparam int OUT_FRAC_BITS = 15;
    localparam int OUT_W         = OUT_FRAC_BITS + 1;

    // cordic datapath
    localparam int NUM_ITER    = 31;
    localparam int CORD_W      = 34;
    localparam int PHASE_SHIFT = 31 - ANGLE_BITS;
    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CORD_W-1:0] ONE_Q30     = 34'sd1073741824;
    localparam logic signed [CORD_W-1:0] HALF_TURN   = 34'sd2147483648;

    // sine and cosine results, signed q2.30 clamped to plus or minus one
    localparam int SC_W = 32;

    // combine datapath
    localparam int PROD_W    = 62;
    localparam int SUM_W     = 63;
    localparam int OUT_SHIFT = 60 - OUT_FRAC_BITS;
    localparam int RND_W     = SUM_W - OUT_SHIFT;

    // pipeline depth: phase fold, one cell per iteration, sign fix and clamp, then the combine stages
    localparam int SINCOS_LAT  = NUM_ITER + 2;
    localparam int COMBINE_LAT = 3;
    localparam int PIPE_LAT    = SINCOS_LAT + COMBINE_LAT;

    // arctangent of 2^-i, 2^32 is one full turn
    localparam logic [29:0] ATAN_TURN32 [NUM_ITER] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
        30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
        30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,       30'd41,
        30'd20,        30'd10,        30'd5,         30'd3,        30'd1,
        30'd1
    };

    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [CORD_W-1:0] t;
        logic                     flip;
    } cordic_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] angle_about_x;
        logic [ANGLE_BITS-1:0] angle_about_y;
        logic [ANGLE_BITS-1:0] angle_about_z;
    } e2q_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] quat_x;
        logic signed [OUT_W-1:0] quat_y;
        logic signed [OUT_W-1:0] quat_z;
        logic signed [OUT_W-1:0] quat_w;
    } e2q_out_t;

endpackage
`default_nettype wire

// ===== rtl/e2q_cordic_cell.sv =====
// one cordic rotation step with its output register
`timescale 1ns / 1ps
`default_nettype none
module e2q_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire e2q_pkg::cordic_t cell_in,
    output e2q_pkg::cordic_t      cell_out
);
    import e2q_pkg::*;

    localparam logic signed [CORD_W-1:0] ATAN = CORD_W'(ATAN_TURN32[STAGE]);

    logic signed [CORD_W-1:0] x_in;
    logic signed [CORD_W-1:0] y_in;
    logic signed [CORD_W-1:0] t_in;
    logic signed [CORD_W-1:0] x_sh;
    logic signed [CORD_W-1:0] y_sh;
    logic                     dir_pos;
    cordic_t                  cell_next;
    cordic_t                  cell_reg;

    always_comb begin
        x_in    = cell_in.x;
        y_in    = cell_in.y;
        t_in    = cell_in.t;
        x_sh    = x_in >>> STAGE;
        y_sh    = y_in >>> STAGE;
        dir_pos = ~t_in[CORD_W-1];
        cell_next.flip = cell_in.flip;
        if (dir_pos) begin
            cell_next.x = x_in - y_sh;
            cell_next.y = y_in + x_sh;
            cell_next.t = t_in - ATAN;
        end else begin
            cell_next.x = x_in + y_sh;
            cell_next.y = y_in - x_sh;
            cell_next.t = t_in + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule
`default_nettype wire

// ===== rtl/e2q_sincos.sv =====
// sine and cosine of half a binary angle through a chain of cordic cells
`timescale 1ns / 1ps
`default_nettype none
module e2q_sincos (
    input  wire logic                                   aclk,
    input  wire logic                                   en,
    input  wire logic        [e2q_pkg::ANGLE_BITS-1:0]  angle,
    output logic signed      [e2q_pkg::SC_W-1:0]        sin_out,
    output logic signed      [e2q_pkg::SC_W-1:0]        cos_out
);
    import e2q_pkg::*;

    cordic_t                  chain [NUM_ITER+1];
    cordic_t                  fold_next;
    cordic_t                  fold_reg;
    logic signed [CORD_W-1:0] phase;
    logic signed [CORD_W-1:0] x_fix;
    logic signed [CORD_W-1:0] y_fix;
    logic signed [SC_W-1:0]   sin_next;
    logic signed [SC_W-1:0]   cos_next;
    logic signed [SC_W-1:0]   sin_reg;
    logic signed [SC_W-1:0]   cos_reg;

    // half angle phase, folded into the right half plane
    always_comb begin
        phase          = CORD_W'(angle) << PHASE_SHIFT;
        fold_next.x    = CORDIC_GAIN;
        fold_next.y    = '0;
        fold_next.flip = (phase > ONE_Q30);
        fold_next.t    = fold_next.flip ? (phase - HALF_TURN) : phase;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fold_reg <= fold_next;
        end
    end

    assign chain[0] = fold_reg;

    for (genvar i = 0; i < NUM_ITER; i++) begin : g_cell
        e2q_cordic_cell #(
            .STAGE (i)
        ) u_cell (
            .aclk     (aclk),
            .en       (en),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    always_comb begin
        x_fix = chain[NUM_ITER].flip ? -chain[NUM_ITER].x : chain[NUM_ITER].x;
        y_fix = chain[NUM_ITER].flip ? -chain[NUM_ITER].y : chain[NUM_ITER].y;
        if (x_fix > ONE_Q30) begin
            cos_next = SC_W'(ONE_Q30);
        end else if (x_fix < -ONE_Q30) begin
            cos_next = SC_W'(-ONE_Q30);
        end else begin
            cos_next = SC_W'(x_fix);
        end
        if (y_fix > ONE_Q30) begin
            sin_next = SC_W'(ONE_Q30);
        end else if (y_fix < -ONE_Q30) begin
            sin_next = SC_W'(-ONE_Q30);
        end else begin
            sin_next = SC_W'(y_fix);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule
`default_nettype wire

// ===== rtl/e2q_combine.sv =====
// pair products, component products and rounding into q1.15 components
`timescale 1ns / 1ps
`default_nettype none
module e2q_combine (
    input  wire logic                               aclk,
    input  wire logic                               en,
    input  wire logic signed [e2q_pkg::SC_W-1:0]    sx,
    input  wire logic signed [e2q_pkg::SC_W-1:0]    cx,
    input  wire logic signed [e2q_pkg::SC_W-1:0]    sy,
    input  wire logic signed [e2q_pkg::SC_W-1:0]    cy,
    input  wire logic signed [e2q_pkg::SC_W-1:0]    sz,
    input  wire logic signed [e2q_pkg::SC_W-1:0]    cz,
    output e2q_pkg::e2q_out_t                       quat
);
    import e2q_pkg::*;

    localparam logic signed [63:0] PAIR_RND = 64'sd1 <<< 29;
    localparam logic signed [SUM_W-1:0] OUT_RND = SUM_W'(64'sd1 <<< (OUT_SHIFT - 1));
    localparam logic signed [RND_W-1:0] Q_MAX = RND_W'((64'sd1 <<< OUT_FRAC_BITS) - 64'sd1);
    localparam logic signed [RND_W-1:0] Q_MIN = RND_W'(-(64'sd1 <<< OUT_FRAC_BITS));

    // stage a: rounded pairs
    logic signed [63:0]     pw_sxcy;
    logic signed [63:0]     pw_cxcy;
    logic signed [63:0]     pw_sxsy;
    logic signed [63:0]     pw_cxsy;
    logic signed [SC_W-1:0] sxcy_reg;
    logic signed [SC_W-1:0] cxcy_reg;
    logic signed [SC_W-1:0] sxsy_reg;
    logic signed [SC_W-1:0] cxsy_reg;
    logic signed [SC_W-1:0] sz_reg;
    logic signed [SC_W-1:0] cz_reg;

    always_comb begin
        pw_sxcy = 64'(sx) * 64'(cy) + PAIR_RND;
        pw_cxcy = 64'(cx) * 64'(cy) + PAIR_RND;
        pw_sxsy = 64'(sx) * 64'(sy) + PAIR_RND;
        pw_cxsy = 64'(cx) * 64'(sy) + PAIR_RND;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sxcy_reg <= pw_sxcy[61:30];
            cxcy_reg <= pw_cxcy[61:30];
            sxsy_reg <= pw_sxsy[61:30];
            cxsy_reg <= pw_cxsy[61:30];
            sz_reg   <= sz;
            cz_reg   <= cz;
        end
    end

    // stage b: pair times third angle
    logic signed [63:0]       pr [8];
    logic signed [PROD_W-1:0] pr_reg [8];

    always_comb begin
        pr[0] = 64'(sxcy_reg) * 64'(cz_reg);
        pr[1] = 64'(cxsy_reg) * 64'(sz_reg);
        pr[2] = 64'(cxsy_reg) * 64'(cz_reg);
        pr[3] = 64'(sxcy_reg) * 64'(sz_reg);
        pr[4] = 64'(cxcy_reg) * 64'(sz_reg);
        pr[5] = 64'(sxsy_reg) * 64'(cz_reg);
        pr[6] = 64'(cxcy_reg) * 64'(cz_reg);
        pr[7] = 64'(sxsy_reg) * 64'(sz_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 8; k++) begin
                pr_reg[k] <= pr[k][PROD_W-1:0];
            end
        end
    end

    // stage c: sum, round half up, saturate
    logic signed [SUM_W-1:0] sum [4];
    logic signed [RND_W-1:0] rnd [4];
    logic signed [OUT_W-1:0] comp [4];
    e2q_out_t                quat_next;
    e2q_out_t                quat_reg;

    always_comb begin
        sum[0] = SUM_W'(pr_reg[0]) - SUM_W'(pr_reg[1]);
        sum[1] = SUM_W'(pr_reg[2]) + SUM_W'(pr_reg[3]);
        sum[2] = SUM_W'(pr_reg[4]) - SUM_W'(pr_reg[5]);
        sum[3] = SUM_W'(pr_reg[6]) + SUM_W'(pr_reg[7]);
        for (int k = 0; k < 4; k++) begin
            rnd[k] = RND_W'((sum[k] + OUT_RND) >>> OUT_SHIFT);
            if (rnd[k] > Q_MAX) begin
                comp[k] = OUT_W'(Q_MAX);
            end else if (rnd[k] < Q_MIN) begin
                comp[k] = OUT_W'(Q_MIN);
            end else begin
                comp[k] = OUT_W'(rnd[k]);
            end
        end
        quat_next.quat_x = comp[0];
        quat_next.quat_y = comp[1];
        quat_next.quat_z = comp[2];
        quat_next.quat_w = comp[3];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quat_reg <= quat_next;
        end
    end

    assign quat = quat_reg;

endmodule
`default_nettype wire

// ===== rtl/euler_to_quaternion.sv =====
// euler angles (z-y-x order) to unit quaternion, top level
//
// input channel s_valid/s_ready/s_data carries three binary angles, one full
// turn being 2^16. output channel m_valid/m_ready/m_data carries the x, y, z
// and w components of the quaternion of rz*ry*rx in signed q1.15, where plus
// one saturates to 32767.
// each transfer in gives exactly one transfer out, in order.
// the pipeline is one phase fold stage, a chain of 31 cordic cells per
// angle, a clamp stage, then pair products, component products and a
// rounding stage that is also the output register.
// throughput is one item per cycle while m_ready is high.
// when the receiver stalls with a result waiting, the whole pipeline holds
// and s_ready drops until the result is taken; no item is lost.
// reset clears only the stage valid flags, so m_valid is low after reset
// and the block takes items right away.
`timescale 1ns / 1ps
`default_nettype none
module euler_to_quaternion (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire e2q_pkg::e2q_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output e2q_pkg::e2q_out_t      m_data
);
    import e2q_pkg::*;

    logic                    adv;
    logic [PIPE_LAT-1:0]     vld_reg;
    logic [PIPE_LAT-1:0]     vld_next;
    logic signed [SC_W-1:0]  sx;
    logic signed [SC_W-1:0]  cx;
    logic signed [SC_W-1:0]  sy;
    logic signed [SC_W-1:0]  cy;
    logic signed [SC_W-1:0]  sz;
    logic signed [SC_W-1:0]  cz;

    // the pipeline moves unless a finished result is waiting
    assign adv     = ~m_valid | m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[PIPE_LAT-1];

    always_comb begin
        vld_next = vld_reg;
        if (adv) begin
            vld_next = {vld_reg[PIPE_LAT-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    e2q_sincos u_sincos_x (
        .aclk    (aclk),
        .en      (adv),
        .angle   (s_data.angle_about_x),
        .sin_out (sx),
        .cos_out (cx)
    );

    e2q_sincos u_sincos_y (
        .aclk    (aclk),
        .en      (adv),
        .angle   (s_data.angle_about_y),
        .sin_out (sy),
        .cos_out (cy)
    );

    e2q_sincos u_sincos_z (
        .aclk    (aclk),
        .en      (adv),
        .angle   (s_data.angle_about_z),
        .sin_out (sz),
        .cos_out (cz)
    );

    e2q_combine u_combine (
        .aclk (aclk),
        .en   (adv),
        .sx   (sx),
        .cx   (cx),
        .sy   (sy),
        .cy   (cy),
        .sz   (sz),
        .cz   (cz),
        .quat (m_data)
    );

endmodule
`default_nettype wire
